[sv/i2cmts_pkg.sv]
// Shared types and codes of the I2C master transaction sequencer.
package i2cmts_pkg;

    // Kind of input word
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // Bus event codes reported by the byte engine
    localparam logic [2:0] BUS_START      = 3'd0;
    localparam logic [2:0] BUS_RSTART     = 3'd1;
    localparam logic [2:0] BUS_ARB_LOST   = 3'd2;
    localparam logic [2:0] BUS_ADDR_ACK   = 3'd3;
    localparam logic [2:0] BUS_ADDR_NACK  = 3'd4;
    localparam logic [2:0] BUS_DATA_ACK   = 3'd5;
    localparam logic [2:0] BUS_DATA_NACK  = 3'd6;
    localparam logic [2:0] BUS_OTHER      = 3'd7;

    // Commands to the byte engine
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_SEND   = 3'd2;
    localparam logic [2:0] CMD_RX_ACK = 3'd3;
    localparam logic [2:0] CMD_RX_NAK = 3'd4;

    // Final status codes
    localparam logic [1:0] FS_OK    = 2'd0;
    localparam logic [1:0] FS_ANACK = 2'd1;
    localparam logic [1:0] FS_ERR   = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_ADDR  = 4'b0100,
        PH_DATA  = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [6:0]  address;
        logic        direction;
        logic [7:0]  bytes_wanted;
        logic [7:0]  bytes_done;
        logic        stop_flag;
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [6:0]  target_address;
        logic        read_not_write;
        logic [7:0]  byte_count;
        logic        stop_after_write;
        logic [2:0]  bus_status;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  command_byte;
        logic        issue_stop;
        logic        done_res;
        logic [1:0]  final_status;
        logic        read_valid;
        logic [7:0]  read_byte;
    } t_result;

endpackage

[sv/i2c_master_transaction_sequencer_top.sv]
// Top level of the I2C master transaction sequencer: state and result registers.
// Each accepted word (a begin request or a bus event from the byte engine) yields
// exactly one result word in the next cycle: the next engine command, any STOP
// request, completion status and any received byte. A new word is taken every
// cycle as long as the result register is empty or being read in the same cycle;
// the only limit is the single result register, so the sustained rate is one word
// per clock. A begin word while a transfer runs drops that transfer and restarts.
module i2c_master_transaction_sequencer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_operation,
    input  logic [6:0] i_target_address,
    input  logic       i_read_not_write,
    input  logic [7:0] i_byte_count,
    input  logic       i_stop_after_write,
    input  logic [2:0] i_bus_status,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_command,
    output logic [7:0] o_command_byte,
    output logic       o_issue_stop,
    output logic       o_done_res,
    output logic [1:0] o_final_status,
    output logic       o_read_valid,
    output logic [7:0] o_read_byte
);

    i2cmts_pkg::t_state  r_state;
    i2cmts_pkg::t_state  n_state;
    i2cmts_pkg::t_item   item;
    i2cmts_pkg::t_result n_result;
    i2cmts_pkg::t_result r_result;
    logic                r_out_valid;
    logic                in_accept;

    // Gather the input word
    assign item = '{
        operation:        i_operation,
        target_address:   i_target_address,
        read_not_write:   i_read_not_write,
        byte_count:       i_byte_count,
        stop_after_write: i_stop_after_write,
        bus_status:       i_bus_status,
        data_byte:        i_data_byte
    };

    // Accept while the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    i2cmts_step u_step (
        .i_state  (r_state),
        .i_item   (item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Advance the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{
                phase:        i2cmts_pkg::PH_IDLE,
                address:      7'd0,
                direction:    1'b0,
                bytes_wanted: 8'd0,
                bytes_done:   8'd0,
                stop_flag:    1'b0
            };
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_command      = r_result.command;
    assign o_command_byte = r_result.command_byte;
    assign o_issue_stop   = r_result.issue_stop;
    assign o_done_res     = r_result.done_res;
    assign o_final_status = r_result.final_status;
    assign o_read_valid   = r_result.read_valid;
    assign o_read_byte    = r_result.read_byte;

    // A finished transfer issues no further command
    a_done_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.done_res |-> r_result.command == i2cmts_pkg::CMD_NONE)
        else $error("command issued with done");

    // Command byte is only nonzero with a send
    a_byte_only_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.command != i2cmts_pkg::CMD_SEND
        |-> r_result.command_byte == 8'd0)
        else $error("command byte without send");

    // Status is only reported with done
    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_result.done_res |-> r_result.final_status == i2cmts_pkg::FS_OK)
        else $error("status without done");

    // A begin word always lands in the start phase and asks for START
    a_begin_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_operation == i2cmts_pkg::OP_BEGIN
        |=> r_state.phase == i2cmts_pkg::PH_START && r_out_valid
            && r_result.command == i2cmts_pkg::CMD_START)
        else $error("begin did not start");

    // Completion returns the sequencer to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_result.done_res |=> r_state.phase == i2cmts_pkg::PH_IDLE)
        else $error("done without idle");

endmodule

[sv/i2cmts_step.sv]
// Next-state and result logic for one word of the transaction sequencer.
module i2cmts_step (
    input  i2cmts_pkg::t_state  i_state,
    input  i2cmts_pkg::t_item   i_item,
    output i2cmts_pkg::t_state  o_state,
    output i2cmts_pkg::t_result o_result
);

    logic [7:0] done_inc;
    logic       stop_wanted;
    logic       rx_more_after_first;
    logic       rx_more_after_inc;

    // Byte counter step and stop rule
    assign done_inc            = i_state.bytes_done + 8'd1;
    assign stop_wanted         = i_state.direction | i_state.stop_flag;
    assign rx_more_after_first = 8'd1 < i_state.bytes_wanted;
    assign rx_more_after_inc   = (done_inc + 8'd1) < i_state.bytes_wanted;

    always_comb begin
        o_state  = i_state;
        o_result = '0;

        if (i_item.operation == i2cmts_pkg::OP_BEGIN) begin
            // Latch the new transfer and request START
            o_state.address      = i_item.target_address;
            o_state.direction    = i_item.read_not_write;
            o_state.bytes_wanted = i_item.byte_count;
            o_state.stop_flag    = i_item.stop_after_write;
            o_state.bytes_done   = 8'd0;
            o_state.phase        = i2cmts_pkg::PH_START;
            o_result.command     = i2cmts_pkg::CMD_START;
        end else begin
            unique case (i_state.phase)
                i2cmts_pkg::PH_IDLE: begin
                    o_state.phase = i2cmts_pkg::PH_IDLE;
                end
                i2cmts_pkg::PH_START: begin
                    // Send the address byte once the bus is ours
                    priority if (i_item.bus_status == i2cmts_pkg::BUS_START ||
                                 i_item.bus_status == i2cmts_pkg::BUS_RSTART) begin
                        o_result.command      = i2cmts_pkg::CMD_SEND;
                        o_result.command_byte = {i_state.address, i_state.direction};
                        o_state.phase         = i2cmts_pkg::PH_ADDR;
                    end else if (i_item.bus_status == i2cmts_pkg::BUS_ARB_LOST) begin
                        o_result.command = i2cmts_pkg::CMD_START;
                    end else begin
                        o_result.done_res     = 1'b1;
                        o_result.final_status = i2cmts_pkg::FS_ERR;
                        o_state.phase         = i2cmts_pkg::PH_IDLE;
                    end
                end
                i2cmts_pkg::PH_ADDR: begin
                    priority if (i_item.bus_status == i2cmts_pkg::BUS_ARB_LOST) begin
                        o_result.command = i2cmts_pkg::CMD_START;
                        o_state.phase    = i2cmts_pkg::PH_START;
                    end else if (i_item.bus_status == i2cmts_pkg::BUS_ADDR_ACK) begin
                        o_state.bytes_done = 8'd0;
                        priority if (i_state.bytes_wanted == 8'd0) begin
                            o_result.done_res     = 1'b1;
                            o_result.final_status = i2cmts_pkg::FS_OK;
                            o_result.issue_stop   = stop_wanted;
                            o_state.phase         = i2cmts_pkg::PH_IDLE;
                        end else if (!i_state.direction) begin
                            o_result.command      = i2cmts_pkg::CMD_SEND;
                            o_result.command_byte = i_item.data_byte;
                            o_state.phase         = i2cmts_pkg::PH_DATA;
                        end else begin
                            o_result.command = rx_more_after_first ?
                                i2cmts_pkg::CMD_RX_ACK : i2cmts_pkg::CMD_RX_NAK;
                            o_state.phase    = i2cmts_pkg::PH_DATA;
                        end
                    end else begin
                        // Address NACK or anything unexpected ends the transfer
                        o_result.done_res     = 1'b1;
                        o_result.final_status =
                            (i_item.bus_status == i2cmts_pkg::BUS_ADDR_NACK) ?
                            i2cmts_pkg::FS_ANACK : i2cmts_pkg::FS_ERR;
                        o_result.issue_stop   = stop_wanted;
                        o_state.phase         = i2cmts_pkg::PH_IDLE;
                    end
                end
                i2cmts_pkg::PH_DATA: begin
                    if (!i_state.direction) begin
                        // Write: next byte on ACK, finish at count
                        if (i_item.bus_status == i2cmts_pkg::BUS_DATA_ACK) begin
                            o_state.bytes_done = done_inc;
                            if (done_inc >= i_state.bytes_wanted) begin
                                o_result.done_res     = 1'b1;
                                o_result.final_status = i2cmts_pkg::FS_OK;
                                o_result.issue_stop   = stop_wanted;
                                o_state.phase         = i2cmts_pkg::PH_IDLE;
                            end else begin
                                o_result.command      = i2cmts_pkg::CMD_SEND;
                                o_result.command_byte = i_item.data_byte;
                            end
                        end else begin
                            o_result.done_res     = 1'b1;
                            o_result.final_status = i2cmts_pkg::FS_ERR;
                            o_result.issue_stop   = stop_wanted;
                            o_state.phase         = i2cmts_pkg::PH_IDLE;
                        end
                    end else begin
                        // Read: deliver the byte, ACK all but the last
                        if (i_item.bus_status == i2cmts_pkg::BUS_DATA_ACK ||
                            i_item.bus_status == i2cmts_pkg::BUS_DATA_NACK) begin
                            o_result.read_valid = 1'b1;
                            o_result.read_byte  = i_item.data_byte;
                            o_state.bytes_done  = done_inc;
                            priority if (done_inc >= i_state.bytes_wanted) begin
                                o_result.done_res     = 1'b1;
                                o_result.final_status = i2cmts_pkg::FS_OK;
                                o_result.issue_stop   = 1'b1;
                                o_state.phase         = i2cmts_pkg::PH_IDLE;
                            end else if (i_item.bus_status ==
                                         i2cmts_pkg::BUS_DATA_NACK) begin
                                o_result.done_res     = 1'b1;
                                o_result.final_status = i2cmts_pkg::FS_ERR;
                                o_result.issue_stop   = 1'b1;
                                o_state.phase         = i2cmts_pkg::PH_IDLE;
                            end else begin
                                o_result.command = rx_more_after_inc ?
                                    i2cmts_pkg::CMD_RX_ACK : i2cmts_pkg::CMD_RX_NAK;
                            end
                        end else begin
                            o_result.done_res     = 1'b1;
                            o_result.final_status = i2cmts_pkg::FS_ERR;
                            o_result.issue_stop   = 1'b1;
                            o_state.phase         = i2cmts_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                    o_state.phase = i2cmts_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/i2c_master_transaction_sequencer_top_tb.sv]
// Self-checking testbench for the I2C master transaction sequencer top level.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_top_tb;

    // Track the sequencer state and hold the result word due for each input word
    class transfer_scoreboard;
        i2cmts_pkg::t_phase  phase;
        logic [6:0]          address;
        logic                direction;
        logic [7:0]          bytes_wanted;
        logic [7:0]          bytes_done;
        logic                stop_flag;
        i2cmts_pkg::t_result expected_results[$];
        int unsigned errors;
        int unsigned n_words;
        int unsigned n_ok;
        int unsigned n_anack;
        int unsigned n_err;
        int unsigned n_read_bytes;

        function new();
            phase        = i2cmts_pkg::PH_IDLE;
            address      = '0;
            direction    = 1'b0;
            bytes_wanted = '0;
            bytes_done   = '0;
            stop_flag    = 1'b0;
            errors       = 0;
            n_words      = 0;
            n_ok         = 0;
            n_anack      = 0;
            n_err        = 0;
            n_read_bytes = 0;
        endfunction

        function logic stop_due();
            return direction || stop_flag;
        endfunction

        // Close the transfer: mark done with a status and drop back to idle
        function i2cmts_pkg::t_result closed(i2cmts_pkg::t_result r, logic [1:0] status,
                                             logic stop);
            r.issue_stop   = stop;
            r.done_res     = 1'b1;
            r.final_status = status;
            phase          = i2cmts_pkg::PH_IDLE;
            case (status)
                i2cmts_pkg::FS_OK:    n_ok++;
                i2cmts_pkg::FS_ANACK: n_anack++;
                default:              n_err++;
            endcase
            return r;
        endfunction

        // ACK every received byte but the last
        function logic [2:0] rx_command();
            logic [7:0] nxt;
            nxt = bytes_done + 8'd1;
            return (nxt < bytes_wanted) ? i2cmts_pkg::CMD_RX_ACK : i2cmts_pkg::CMD_RX_NAK;
        endfunction

        // Advance the state by one word and work out its result word
        function i2cmts_pkg::t_result next_result(i2cmts_pkg::t_item w);
            i2cmts_pkg::t_result r;
            r = '0;
            if (w.operation == i2cmts_pkg::OP_BEGIN) begin
                address      = w.target_address;
                direction    = w.read_not_write;
                bytes_wanted = w.byte_count;
                stop_flag    = w.stop_after_write;
                bytes_done   = '0;
                phase        = i2cmts_pkg::PH_START;
                r.command    = i2cmts_pkg::CMD_START;
                return r;
            end
            case (phase)
                i2cmts_pkg::PH_START: begin
                    if (w.bus_status == i2cmts_pkg::BUS_START ||
                        w.bus_status == i2cmts_pkg::BUS_RSTART) begin
                        r.command      = i2cmts_pkg::CMD_SEND;
                        r.command_byte = {address, direction};
                        phase          = i2cmts_pkg::PH_ADDR;
                    end else if (w.bus_status == i2cmts_pkg::BUS_ARB_LOST) begin
                        r.command = i2cmts_pkg::CMD_START;
                    end else begin
                        r = closed(r, i2cmts_pkg::FS_ERR, 1'b0);
                    end
                end
                i2cmts_pkg::PH_ADDR: begin
                    if (w.bus_status == i2cmts_pkg::BUS_ARB_LOST) begin
                        r.command = i2cmts_pkg::CMD_START;
                        phase     = i2cmts_pkg::PH_START;
                    end else if (w.bus_status == i2cmts_pkg::BUS_ADDR_ACK) begin
                        bytes_done = '0;
                        if (bytes_wanted == 8'd0) begin
                            r = closed(r, i2cmts_pkg::FS_OK, stop_due());
                        end else if (!direction) begin
                            r.command      = i2cmts_pkg::CMD_SEND;
                            r.command_byte = w.data_byte;
                            phase          = i2cmts_pkg::PH_DATA;
                        end else begin
                            r.command = rx_command();
                            phase     = i2cmts_pkg::PH_DATA;
                        end
                    end else if (w.bus_status == i2cmts_pkg::BUS_ADDR_NACK) begin
                        r = closed(r, i2cmts_pkg::FS_ANACK, stop_due());
                    end else begin
                        r = closed(r, i2cmts_pkg::FS_ERR, stop_due());
                    end
                end
                i2cmts_pkg::PH_DATA: begin
                    if (!direction) begin
                        if (w.bus_status == i2cmts_pkg::BUS_DATA_ACK) begin
                            bytes_done = bytes_done + 8'd1;
                            if (bytes_done >= bytes_wanted) begin
                                r = closed(r, i2cmts_pkg::FS_OK, stop_due());
                            end else begin
                                r.command      = i2cmts_pkg::CMD_SEND;
                                r.command_byte = w.data_byte;
                            end
                        end else begin
                            r = closed(r, i2cmts_pkg::FS_ERR, stop_due());
                        end
                    end else begin
                        if (w.bus_status == i2cmts_pkg::BUS_DATA_ACK ||
                            w.bus_status == i2cmts_pkg::BUS_DATA_NACK) begin
                            r.read_valid = 1'b1;
                            r.read_byte  = w.data_byte;
                            n_read_bytes++;
                            bytes_done   = bytes_done + 8'd1;
                            if (bytes_done >= bytes_wanted) begin
                                r = closed(r, i2cmts_pkg::FS_OK, 1'b1);
                            end else if (w.bus_status == i2cmts_pkg::BUS_DATA_NACK) begin
                                r = closed(r, i2cmts_pkg::FS_ERR, 1'b1);
                            end else begin
                                r.command = rx_command();
                            end
                        end else begin
                            r = closed(r, i2cmts_pkg::FS_ERR, 1'b1);
                        end
                    end
                end
                default: begin
                    // event while idle: ignored, result stays all zero
                    phase = i2cmts_pkg::PH_IDLE;
                end
            endcase
            return r;
        endfunction

        function void note_word(i2cmts_pkg::t_item w);
            n_words++;
            expected_results.push_back(next_result(w));
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(i2cmts_pkg::t_result got);
            i2cmts_pkg::t_result exp_r;
            if (expected_results.size() == 0) begin
                $error("result word with no expectation pending");
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            compare_field("command", exp_r.command, got.command);
            compare_field("command_byte", exp_r.command_byte, got.command_byte);
            compare_field("issue_stop", exp_r.issue_stop, got.issue_stop);
            compare_field("done_res", exp_r.done_res, got.done_res);
            compare_field("final_status", exp_r.final_status, got.final_status);
            compare_field("read_valid", exp_r.read_valid, got.read_valid);
            compare_field("read_byte", exp_r.read_byte, got.read_byte);
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       operation = 1'b0;
    logic [6:0] target_address = '0;
    logic       read_not_write = 1'b0;
    logic [7:0] byte_count = '0;
    logic       stop_after_write = 1'b0;
    logic [2:0] bus_status = '0;
    logic [7:0] data_byte = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] command;
    logic [7:0] command_byte;
    logic       issue_stop;
    logic       done_res;
    logic [1:0] final_status;
    logic       read_valid;
    logic [7:0] read_byte;

    bit steady = 1'b0;
    transfer_scoreboard sb;

    i2c_master_transaction_sequencer_top dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_operation        (operation),
        .i_target_address   (target_address),
        .i_read_not_write   (read_not_write),
        .i_byte_count       (byte_count),
        .i_stop_after_write (stop_after_write),
        .i_bus_status       (bus_status),
        .i_data_byte        (data_byte),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_command          (command),
        .o_command_byte     (command_byte),
        .o_issue_stop       (issue_stop),
        .o_done_res         (done_res),
        .o_final_status     (final_status),
        .o_read_valid       (read_valid),
        .o_read_byte        (read_byte)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Stall the result side at random, except during the steady stretch
    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 14);
    end

    // Check every result word taken from the block
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result({command, command_byte, issue_stop, done_res,
                             final_status, read_valid, read_byte});
        end
    end

    function automatic i2cmts_pkg::t_item begin_word(logic [6:0] addr, logic rnw,
                                                     logic [7:0] count, logic stop);
        i2cmts_pkg::t_item w;
        w.operation        = i2cmts_pkg::OP_BEGIN;
        w.target_address   = addr;
        w.read_not_write   = rnw;
        w.byte_count       = count;
        w.stop_after_write = stop;
        w.bus_status       = 3'($urandom_range(7));
        w.data_byte        = 8'($urandom_range(255));
        return w;
    endfunction

    function automatic i2cmts_pkg::t_item event_word(logic [2:0] status, logic [7:0] data);
        i2cmts_pkg::t_item w;
        w.operation        = i2cmts_pkg::OP_EVENT;
        w.target_address   = 7'($urandom_range(127));
        w.read_not_write   = 1'($urandom_range(1));
        w.byte_count       = 8'($urandom_range(255));
        w.stop_after_write = 1'($urandom_range(1));
        w.bus_status       = status;
        w.data_byte        = data;
        return w;
    endfunction

    // Present one word, hold it until accepted, then record it
    task automatic send_word(input i2cmts_pkg::t_item w);
        while (!steady && $urandom_range(99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        operation        <= w.operation;
        target_address   <= w.target_address;
        read_not_write   <= w.read_not_write;
        byte_count       <= w.byte_count;
        stop_after_write <= w.stop_after_write;
        bus_status       <= w.bus_status;
        data_byte        <= w.data_byte;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_word(w);
    endtask

    // Drive one transfer with bus events that mostly follow the protocol
    task automatic run_transfer(input bit clean, input logic rnw, input logic [7:0] count);
        int         steps;
        int         r;
        logic [2:0] st;
        logic [7:0] nxt;
        send_word(begin_word(7'($urandom_range(127)), rnw, count, 1'($urandom_range(1))));
        steps = 0;
        while (sb.phase != i2cmts_pkg::PH_IDLE && steps < 300) begin
            // drop out now and then so the next begin cuts the transfer short
            if (!clean && $urandom_range(99) < 2) break;
            r = clean ? 99 : $urandom_range(99);
            case (sb.phase)
                i2cmts_pkg::PH_START: begin
                    if (r < 15) st = i2cmts_pkg::BUS_ARB_LOST;
                    else st = $urandom_range(1) ? i2cmts_pkg::BUS_RSTART
                                                : i2cmts_pkg::BUS_START;
                end
                i2cmts_pkg::PH_ADDR: begin
                    if (r < 8) st = i2cmts_pkg::BUS_ADDR_NACK;
                    else if (r < 14) st = i2cmts_pkg::BUS_ARB_LOST;
                    else st = i2cmts_pkg::BUS_ADDR_ACK;
                end
                default: begin
                    nxt = sb.bytes_done + 8'd1;
                    if (!sb.direction) st = i2cmts_pkg::BUS_DATA_ACK;
                    else st = (nxt < sb.bytes_wanted) ? i2cmts_pkg::BUS_DATA_ACK
                                                      : i2cmts_pkg::BUS_DATA_NACK;
                    if (sb.direction && r < 6) begin
                        st = (st == i2cmts_pkg::BUS_DATA_ACK) ? i2cmts_pkg::BUS_DATA_NACK
                                                              : i2cmts_pkg::BUS_DATA_ACK;
                    end
                end
            endcase
            if (!clean && $urandom_range(99) < 5) st = 3'($urandom_range(7));
            send_word(event_word(st, 8'($urandom_range(255))));
            steps++;
        end
    endtask

    initial begin
        #2_000_000;
        $display("i2c_master_transaction_sequencer_top test failed");
        $finish;
    end

    initial begin
        int unsigned start_words;
        int          n;
        logic [7:0]  count;

        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored event, arbitration retry, address extremes, all endings
        send_word(event_word(i2cmts_pkg::BUS_DATA_ACK, 8'hFF));
        send_word(begin_word(7'h7F, 1'b0, 8'd1, 1'b1));
        send_word(event_word(i2cmts_pkg::BUS_ARB_LOST, 8'h00));
        send_word(event_word(i2cmts_pkg::BUS_START, 8'h00));
        send_word(event_word(i2cmts_pkg::BUS_ADDR_ACK, 8'hFF));
        send_word(event_word(i2cmts_pkg::BUS_DATA_ACK, 8'h00));
        // zero byte count on a read ends at the address ACK
        send_word(begin_word(7'h00, 1'b1, 8'd0, 1'b0));
        send_word(event_word(i2cmts_pkg::BUS_RSTART, 8'h00));
        send_word(event_word(i2cmts_pkg::BUS_ADDR_ACK, 8'h00));
        // address NACK on a write without stop
        send_word(begin_word(7'h55, 1'b0, 8'd0, 1'b0));
        send_word(event_word(i2cmts_pkg::BUS_START, 8'h00));
        send_word(event_word(i2cmts_pkg::BUS_ADDR_NACK, 8'h00));
        // read NACKed before the last byte
        send_word(begin_word(7'h2A, 1'b1, 8'd3, 1'b0));
        send_word(event_word(i2cmts_pkg::BUS_START, 8'h00));
        send_word(event_word(i2cmts_pkg::BUS_ADDR_ACK, 8'h00));
        send_word(event_word(i2cmts_pkg::BUS_DATA_NACK, 8'hA5));
        // read ACKed on its last byte
        send_word(begin_word(7'h11, 1'b1, 8'd1, 1'b1));
        send_word(event_word(i2cmts_pkg::BUS_START, 8'h00));
        send_word(event_word(i2cmts_pkg::BUS_ADDR_ACK, 8'h00));
        send_word(event_word(i2cmts_pkg::BUS_DATA_ACK, 8'h5A));
        // bad status while waiting for START
        send_word(begin_word(7'h33, 1'b0, 8'd2, 1'b0));
        send_word(event_word(i2cmts_pkg::BUS_OTHER, 8'h00));
        // begin while busy, then a bad status after the address on a read
        send_word(begin_word(7'h44, 1'b0, 8'd5, 1'b1));
        send_word(event_word(i2cmts_pkg::BUS_START, 8'h00));
        send_word(begin_word(7'h66, 1'b1, 8'd2, 1'b1));
        send_word(event_word(i2cmts_pkg::BUS_START, 8'h00));
        send_word(event_word(i2cmts_pkg::BUS_DATA_NACK, 8'h00));

        // Random: one full-length read, then mostly short transfers
        start_words = sb.n_words;
        run_transfer(1'b1, 1'b1, 8'd255);
        n = 0;
        while (sb.n_words - start_words < 800) begin
            steady = (n >= 20 && n < 40);
            if (n == 50) begin
                // hold off until the block has drained
                in_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
            count = ($urandom_range(99) < 10) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(4));
            run_transfer(1'b0, 1'($urandom_range(1)), count);
            if (sb.phase == i2cmts_pkg::PH_IDLE && $urandom_range(99) < 10) begin
                send_word(event_word(3'($urandom_range(7)), 8'($urandom_range(255))));
            end
            n++;
        end
        steady = 1'b0;

        // Drain
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Drove %0d words over %0d random transfers; %0d bytes read.",
                 sb.n_words, n + 1, sb.n_read_bytes);
        $display("Transfers closed: %0d success, %0d address NACK, %0d error.",
                 sb.n_ok, sb.n_anack, sb.n_err);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("i2c_master_transaction_sequencer_top test passed");
        end else begin
            $display("i2c_master_transaction_sequencer_top test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/i2cmts_pkg.sv
sv/i2cmts_step.sv
sv/i2c_master_transaction_sequencer_top.sv
tb/i2c_master_transaction_sequencer_top_tb.sv
